>>> rtl/smcs_pkg.sv
// shared types, codes and helpers of the scan match candidate scorer
package smcs_pkg;

	// parameter defaults
	localparam int unsigned GRID_SIDE_DEF  = 256;
	localparam int unsigned MAX_POINTS_DEF = 1024;

	// field widths
	localparam int unsigned COORD_W    = 10;
	localparam int unsigned CELL_W     = 8;
	localparam int unsigned DIM_W      = 9;
	localparam int unsigned SCORE_W    = 17;
	localparam int unsigned RAW_W      = 18;
	localparam int unsigned ADDR_MAX_W = 24;
	localparam int unsigned QSTEP_W    = 5;
	localparam int unsigned CFG_IDX_W  = 2;

	// command queue depth
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;

	// saturation limit of the raw sum
	localparam logic [RAW_W-1:0] RAW_MAX = '1;

	// function codes of an input item
	localparam logic [1:0] FUNC_GRID_WR = 2'd0;
	localparam logic [1:0] FUNC_APPEND  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR   = 2'd2;
	localparam logic [1:0] FUNC_SCORE   = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

	// one classified command in the queue
	typedef struct packed {
		logic [1:0]               op;
		logic [ADDR_MAX_W-1:0]    addr;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [CELL_W-1:0]        value;
	} cmd_t;

	// position inside 0 .. lim-1
	function automatic logic in_bounds(input logic signed [COORD_W:0] pos,
		input logic [DIM_W-1:0] lim);
		in_bounds = !pos[COORD_W] && (pos[COORD_W-1:0] < {1'b0, lim});
	endfunction

	// row-major cell address
	function automatic logic [ADDR_MAX_W-1:0] grid_addr(input logic [DIM_W-1:0] row,
		input logic [DIM_W-1:0] col, input int unsigned side);
		grid_addr = ADDR_MAX_W'(row) * ADDR_MAX_W'(side) + ADDR_MAX_W'(col);
	endfunction

endpackage

>>> rtl/scan_match_candidate_scorer.sv
// Correlative scan match candidate scorer. Items load an 8-bit occupancy grid
// (func 0), append scan points (func 1), clear the point list (func 2) or score a
// candidate offset (func 3); only a score gives a result transaction, carrying the
// raw grid sum and the floored score sum*65536/(255*count). A front end decodes each
// item and drops out-of-range grid writes, a four-entry command queue follows, and
// the back end executes one command at a time. A score walks the point memory,
// bounded by its single read port feeding one grid read per cycle, then runs the
// bit-serial divider and issues the result. The grid and the point list need no
// clearing after reset; grid cells must be written before a score reads them.
// Configuration writes are taken any cycle (ready stays high) and must only be
// issued while the block is idle.
module scan_match_candidate_scorer #(
	parameter int unsigned GRID_SIDE  = smcs_pkg::GRID_SIDE_DEF,
	parameter int unsigned MAX_POINTS = smcs_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          func,
	input  logic signed [smcs_pkg::COORD_W-1:0] coord_x,
	input  logic signed [smcs_pkg::COORD_W-1:0] coord_y,
	input  logic [smcs_pkg::CELL_W-1:0]         cell_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [smcs_pkg::SCORE_W-1:0]        score_fraction,
	output logic [smcs_pkg::RAW_W-1:0]          raw_sum,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [smcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [smcs_pkg::DIM_W-1:0]          cfg_data
);

	localparam int unsigned SIDE_CLAMP = GRID_SIDE < 511 ? GRID_SIDE : 511;

	logic [smcs_pkg::DIM_W-1:0] grid_width_q;
	logic [smcs_pkg::DIM_W-1:0] grid_height_q;
	logic [smcs_pkg::DIM_W-1:0] eff_w;
	logic [smcs_pkg::DIM_W-1:0] eff_h;
	smcs_pkg::cmd_t             front_cmd;
	smcs_pkg::cmd_t             head_cmd;
	logic                       keep;
	logic                       q_full;
	logic                       q_push;
	logic                       q_pop;
	logic                       head_valid;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= smcs_pkg::DIM_W'(256);
			grid_height_q <= smcs_pkg::DIM_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				smcs_pkg::CFG_WIDTH:  grid_width_q  <= cfg_data;
				smcs_pkg::CFG_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// dimensions in use saturate at the grid side
	always_comb begin
		eff_w = (grid_width_q > smcs_pkg::DIM_W'(SIDE_CLAMP)) ?
			smcs_pkg::DIM_W'(SIDE_CLAMP) : grid_width_q;
		eff_h = (grid_height_q > smcs_pkg::DIM_W'(SIDE_CLAMP)) ?
			smcs_pkg::DIM_W'(SIDE_CLAMP) : grid_height_q;
	end

	// input transaction goes to the queue unless dropped
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full && keep;

	smcs_front #(
		.GRID_SIDE(GRID_SIDE)
	) u_front (
		.func      (func),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.cell_value(cell_value),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.cmd       (front_cmd),
		.keep      (keep)
	);

	smcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (front_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	smcs_back #(
		.GRID_SIDE (GRID_SIDE),
		.MAX_POINTS(MAX_POINTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (head_valid),
		.cmd           (head_cmd),
		.cmd_pop       (q_pop),
		.eff_w         (eff_w),
		.eff_h         (eff_h),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.score_fraction(score_fraction),
		.raw_sum       (raw_sum)
	);

endmodule

>>> rtl/smcs_front.sv
// front end: decodes an input item into a queue command
module smcs_front #(
	parameter int unsigned GRID_SIDE = smcs_pkg::GRID_SIDE_DEF
) (
	input  logic [1:0]                          func,
	input  logic signed [smcs_pkg::COORD_W-1:0] coord_x,
	input  logic signed [smcs_pkg::COORD_W-1:0] coord_y,
	input  logic [smcs_pkg::CELL_W-1:0]         cell_value,
	input  logic [smcs_pkg::DIM_W-1:0]          eff_w,
	input  logic [smcs_pkg::DIM_W-1:0]          eff_h,
	output smcs_pkg::cmd_t                      cmd,
	output logic                                keep
);

	logic wr_inb;

	// bounds check and address of a grid write
	always_comb begin
		wr_inb = smcs_pkg::in_bounds({coord_x[smcs_pkg::COORD_W-1], coord_x}, eff_w) &&
			smcs_pkg::in_bounds({coord_y[smcs_pkg::COORD_W-1], coord_y}, eff_h);
		cmd.op    = func;
		cmd.addr  = smcs_pkg::grid_addr(coord_y[smcs_pkg::DIM_W-1:0],
			coord_x[smcs_pkg::DIM_W-1:0], GRID_SIDE);
		cmd.cx    = coord_x;
		cmd.cy    = coord_y;
		cmd.value = cell_value;
	end

	// out-of-range grid writes are dropped here
	always_comb begin
		unique case (func)
			smcs_pkg::FUNC_GRID_WR: keep = wr_inb;
			smcs_pkg::FUNC_APPEND:  keep = 1'b1;
			smcs_pkg::FUNC_CLEAR:   keep = 1'b1;
			smcs_pkg::FUNC_SCORE:   keep = 1'b1;
			default:                keep = 1'b0;
		endcase
	end

endmodule

>>> rtl/smcs_queue.sv
// short command queue between front end and back end
module smcs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  smcs_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output smcs_pkg::cmd_t head_cmd
);

	smcs_pkg::cmd_t                entries_q [smcs_pkg::QUEUE_DEPTH];
	logic [smcs_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [smcs_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [smcs_pkg::QPTR_W:0]     fill_q;

	assign full       = fill_q == (smcs_pkg::QPTR_W+1)'(smcs_pkg::QUEUE_DEPTH);
	assign head_valid = fill_q != '0;
	assign head_cmd   = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// queue discipline
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop) else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (smcs_pkg::QPTR_W+1)'(smcs_pkg::QUEUE_DEPTH))
		else $error("queue fill level beyond depth");

endmodule

>>> rtl/smcs_div.sv
// restoring divider, one quotient bit per cycle, for the normalized score
module smcs_div #(
	parameter int unsigned W = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [W-1:0]                  num,
	input  logic [W-1:0]                  den,
	output logic                          done,
	output logic [smcs_pkg::SCORE_W-1:0]  quo
);

	logic                           busy_q;
	logic                           first_q;
	logic                           done_q;
	logic [smcs_pkg::QSTEP_W-1:0]   step_q;
	logic [W:0]                     rem_q;
	logic [W-1:0]                   den_q;
	logic [smcs_pkg::SCORE_W-1:0]   quo_q;
	logic [W:0]                     trial;
	logic                           ge;

	// first step takes the integer bit, later steps shift in a zero
	always_comb begin
		trial = first_q ? rem_q : {rem_q[W-1:0], 1'b0};
		ge    = trial >= {1'b0, den_q};
	end

	assign done = done_q;
	assign quo  = quo_q;

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
			quo_q <= {quo_q[smcs_pkg::SCORE_W-2:0], ge};
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			first_q <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				step_q  <= smcs_pkg::QSTEP_W'(smcs_pkg::SCORE_W - 1);
			end else if (busy_q) begin
				first_q <= 1'b0;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/smcs_back.sv
// back end: grid and point storage, candidate walk and result register
module smcs_back #(
	parameter int unsigned GRID_SIDE  = smcs_pkg::GRID_SIDE_DEF,
	parameter int unsigned MAX_POINTS = smcs_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  smcs_pkg::cmd_t                cmd,
	output logic                          cmd_pop,
	input  logic [smcs_pkg::DIM_W-1:0]    eff_w,
	input  logic [smcs_pkg::DIM_W-1:0]    eff_h,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [smcs_pkg::SCORE_W-1:0]  score_fraction,
	output logic [smcs_pkg::RAW_W-1:0]    raw_sum
);

	localparam int unsigned GRID_DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int unsigned ADDR_W = GRID_DEPTH > 1 ? $clog2(GRID_DEPTH) : 1;
	localparam int unsigned IDX_W  = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int unsigned SUM_W  = $clog2(255 * MAX_POINTS + 1);
	localparam int unsigned EXT_W  = SUM_W > smcs_pkg::RAW_W ? SUM_W : smcs_pkg::RAW_W;
	localparam int unsigned CW     = smcs_pkg::COORD_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_WALK  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]                     state_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               rd_idx_q;
	logic signed [CW-1:0]           cx_q;
	logic signed [CW-1:0]           cy_q;
	logic [SUM_W-1:0]               sum_q;

	logic [smcs_pkg::CELL_W-1:0]    grid_mem [GRID_DEPTH];
	logic [2*CW-1:0]                pt_mem [MAX_POINTS];

	logic [2*CW-1:0]                pt_s1;
	logic                           v_s1;
	logic [ADDR_W-1:0]              addr_s2;
	logic                           hit_s2;
	logic                           v_s2;
	logic [smcs_pkg::CELL_W-1:0]    gval_s3;
	logic                           hit_s3;
	logic                           v_s3;

	logic                           out_valid_q;
	logic [smcs_pkg::SCORE_W-1:0]   score_q;
	logic [smcs_pkg::RAW_W-1:0]     raw_q;

	logic                           rd_en;
	logic                           do_gwr;
	logic                           do_append;
	logic                           do_clear;
	logic                           do_score;
	logic                           div_start;
	logic                           div_done;
	logic [smcs_pkg::SCORE_W-1:0]   div_quo;
	logic [SUM_W-1:0]               den;
	logic signed [CW:0]             sx;
	logic signed [CW:0]             sy;
	logic [smcs_pkg::ADDR_MAX_W-1:0] addr_full;
	logic                           hit;
	logic [EXT_W-1:0]               sum_ext;
	logic                           out_load;
	logic                           out_take;

	// command dispatch, only from idle
	always_comb begin
		cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
		do_gwr    = cmd_pop && (cmd.op == smcs_pkg::FUNC_GRID_WR);
		do_append = cmd_pop && (cmd.op == smcs_pkg::FUNC_APPEND) &&
			(count_q < CNT_W'(MAX_POINTS));
		do_clear  = cmd_pop && (cmd.op == smcs_pkg::FUNC_CLEAR);
		do_score  = cmd_pop && (cmd.op == smcs_pkg::FUNC_SCORE);
		rd_en     = (state_q == ST_WALK) && (rd_idx_q < count_q);
		div_start = (state_q == ST_DRAIN) && !v_s1 && !v_s2 && !v_s3;
		out_take  = out_valid_q && !out_stall;
		out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	// shifted point position and its cell
	always_comb begin
		sx        = {pt_s1[2*CW-1], pt_s1[2*CW-1:CW]} + {cx_q[CW-1], cx_q};
		sy        = {pt_s1[CW-1], pt_s1[CW-1:0]} + {cy_q[CW-1], cy_q};
		hit       = smcs_pkg::in_bounds(sx, eff_w) && smcs_pkg::in_bounds(sy, eff_h);
		addr_full = smcs_pkg::grid_addr(sy[smcs_pkg::DIM_W-1:0],
			sx[smcs_pkg::DIM_W-1:0], GRID_SIDE);
	end

	// divisor is 255 times the point count
	assign den = (SUM_W'(count_q) << 8) - SUM_W'(count_q);

	smcs_div #(
		.W(SUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (sum_q),
		.den   (den),
		.done  (div_done),
		.quo   (div_quo)
	);

	// grid memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (do_gwr) begin
			grid_mem[cmd.addr[ADDR_W-1:0]] <= cmd.value;
		end
		if (v_s2 && hit_s2) begin
			gval_s3 <= grid_mem[addr_s2];
		end
	end

	// point memory: append port and walk read port
	always_ff @(posedge clk) begin
		if (do_append) begin
			pt_mem[count_q[IDX_W-1:0]] <= {cmd.cx, cmd.cy};
		end
		if (rd_en) begin
			pt_s1 <= pt_mem[rd_idx_q[IDX_W-1:0]];
		end
	end

	// address stage and candidate payload
	always_ff @(posedge clk) begin
		if (v_s1) begin
			addr_s2 <= addr_full[ADDR_W-1:0];
			hit_s2  <= hit;
		end
		if (do_score) begin
			cx_q <= cmd.cx;
			cy_q <= cmd.cy;
		end
	end

	// raw sum widened for the saturation check
	always_comb begin
		sum_ext = EXT_W'(sum_q);
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			score_q <= (count_q == '0) ? '0 : div_quo;
			raw_q   <= (sum_ext > EXT_W'(smcs_pkg::RAW_MAX)) ? smcs_pkg::RAW_MAX :
				sum_ext[smcs_pkg::RAW_W-1:0];
		end
	end

	// sequencer, walk pipeline valids and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			sum_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			hit_s3      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1   <= rd_en;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			hit_s3 <= v_s2 && hit_s2;
			if (v_s3 && hit_s3) begin
				sum_q <= sum_q + SUM_W'(gval_s3);
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (do_append) begin
				count_q <= count_q + 1'b1;
			end
			if (do_clear) begin
				count_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_score) begin
						sum_q    <= '0;
						rd_idx_q <= '0;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!rd_en) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign score_fraction = score_q;
	assign raw_sum        = raw_q;

	// checks on the walk and the normalization
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS)) else $error("point count beyond capacity");
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !v_s1 && !v_s2 && !v_s3 && !hit_s3)
		else $error("walk pipeline busy at divide start");
	a_sum_le_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> sum_q <= den) else $error("sum above full score");
	a_score_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> score_q <= smcs_pkg::SCORE_W'(65536))
		else $error("score above one");

endmodule

>>> test/tb.sv
// self-checking testbench of the scan match candidate scorer
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_SIDE      = smcs_pkg::GRID_SIDE_DEF;
	localparam int MAX_POINTS     = smcs_pkg::MAX_POINTS_DEF;
	localparam int GRID_CELLS     = GRID_SIDE * GRID_SIDE;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int FULL_SIDE      = 4;
	localparam int FULL_POINTS    = 20;
	localparam int PHASE_ITEMS    = 90;

	// register indexes with no register behind them
	localparam logic [smcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [smcs_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [smcs_pkg::SCORE_W-1:0] score;
		logic [smcs_pkg::RAW_W-1:0]   raw;
	} score_pair_t;

	logic                                clk;
	logic                                arst_n     = 1'b0;
	logic                                in_valid   = 1'b0;
	logic                                in_stall;
	logic [1:0]                          func       = smcs_pkg::FUNC_CLEAR;
	logic signed [smcs_pkg::COORD_W-1:0] coord_x    = '0;
	logic signed [smcs_pkg::COORD_W-1:0] coord_y    = '0;
	logic [smcs_pkg::CELL_W-1:0]         cell_value = '0;
	logic                                out_valid;
	logic                                out_stall  = 1'b0;
	logic [smcs_pkg::SCORE_W-1:0]        score_fraction;
	logic [smcs_pkg::RAW_W-1:0]          raw_sum;
	logic                                cfg_valid  = 1'b0;
	logic                                cfg_ready;
	logic [smcs_pkg::CFG_IDX_W-1:0]      cfg_index  = smcs_pkg::CFG_WIDTH;
	logic [smcs_pkg::DIM_W-1:0]          cfg_data   = '0;

	// shadow copy of the grid, the point list and the dimension registers
	logic [smcs_pkg::CELL_W-1:0] grid_mem [GRID_CELLS];
	bit                          cell_known [GRID_CELLS];
	int                          pt_x [MAX_POINTS];
	int                          pt_y [MAX_POINTS];
	int                          pt_count   = 0;
	logic [smcs_pkg::DIM_W-1:0]  width_reg  = 9'd256;
	logic [smcs_pkg::DIM_W-1:0]  height_reg = 9'd256;
	score_pair_t                 pending_scores [$];

	int items_sent     = 0;
	int scores_checked = 0;
	int cfg_writes     = 0;
	int fail_count     = 0;
	int peak_points    = 0;
	int in_idle_pct    = 0;
	int out_stall_pct  = 0;
	int hold_req       = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	scan_match_candidate_scorer u_dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int as_coord(input int v);
		logic signed [smcs_pkg::COORD_W-1:0] c;
		c = v[smcs_pkg::COORD_W-1:0];
		return int'(c);
	endfunction

	// register values above the grid side act as the full side
	function automatic int active_dim(input logic [smcs_pkg::DIM_W-1:0] d);
		return (d > GRID_SIDE) ? GRID_SIDE : int'(d);
	endfunction

	function automatic bit on_grid(input int x, input int y);
		return x >= 0 && y >= 0 && x < active_dim(width_reg) &&
			y < active_dim(height_reg);
	endfunction

	function automatic int pick_coord();
		return int'($urandom_range(1023)) - 512;
	endfunction

	// mostly a cluster near the origin so shifted points hit the grid
	function automatic int pick_point();
		return ($urandom_range(99) < 70) ? int'($urandom_range(40)) : pick_coord();
	endfunction

	function automatic int pick_shift();
		return ($urandom_range(99) < 70) ? int'($urandom_range(16)) - 8 : pick_coord();
	endfunction

	// advance the shadow state by one accepted command, queue the score it yields
	function automatic void shadow_apply(input logic [1:0] f, input int cx, input int cy,
		input int v);
		longint unsigned sum;
		longint unsigned frac;
		score_pair_t     res;
		sum  = 0;
		frac = 0;
		case (f)
			smcs_pkg::FUNC_GRID_WR: begin
				if (on_grid(cx, cy)) begin
					grid_mem[cy * GRID_SIDE + cx]   = v[smcs_pkg::CELL_W-1:0];
					cell_known[cy * GRID_SIDE + cx] = 1'b1;
				end
			end
			smcs_pkg::FUNC_APPEND: begin
				if (pt_count < MAX_POINTS) begin
					pt_x[pt_count] = cx;
					pt_y[pt_count] = cy;
					pt_count++;
				end
				if (pt_count > peak_points)
					peak_points = pt_count;
			end
			smcs_pkg::FUNC_CLEAR: begin
				pt_count = 0;
			end
			smcs_pkg::FUNC_SCORE: begin
				for (int j = 0; j < pt_count; j++)
					if (on_grid(pt_x[j] + cx, pt_y[j] + cy))
						sum += grid_mem[(pt_y[j] + cy) * GRID_SIDE + pt_x[j] + cx];
				// floored division, zero for an empty list
				if (pt_count != 0)
					frac = (sum << 16) / longint'(255 * pt_count);
				res.score = frac[smcs_pkg::SCORE_W-1:0];
				res.raw   = (sum > smcs_pkg::RAW_MAX) ? smcs_pkg::RAW_MAX :
					sum[smcs_pkg::RAW_W-1:0];
				pending_scores.insert(pending_scores.size(), res);
			end
		endcase
	endfunction

	// offer one command and wait for its transaction
	task automatic send_command(input logic [1:0] f, input int x, input int y, input int v);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		coord_x    <= x[smcs_pkg::COORD_W-1:0];
		coord_y    <= y[smcs_pkg::COORD_W-1:0];
		cell_value <= v[smcs_pkg::CELL_W-1:0];
		do @(posedge clk); while (in_stall);
		shadow_apply(f, as_coord(x), as_coord(y), v);
		items_sent++;
	endtask

	// write every cell the candidate will read before scoring it
	task automatic score_candidate(input int cx, input int cy);
		int x;
		int y;
		for (int j = 0; j < pt_count; j++) begin
			x = pt_x[j] + cx;
			y = pt_y[j] + cy;
			if (on_grid(x, y) && !cell_known[y * GRID_SIDE + x])
				send_command(smcs_pkg::FUNC_GRID_WR, x, y, $urandom_range(255));
		end
		send_command(smcs_pkg::FUNC_SCORE, cx, cy, $urandom_range(255));
	endtask

	// wait for all scores, then let trailing load commands drain
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [smcs_pkg::CFG_IDX_W-1:0] idx, input int d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d[smcs_pkg::DIM_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			smcs_pkg::CFG_WIDTH:  width_reg  = d[smcs_pkg::DIM_W-1:0];
			smcs_pkg::CFG_HEIGHT: height_reg = d[smcs_pkg::DIM_W-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	// reprogram the grid size once the block is idle; spare indexes must do nothing
	task automatic program_dims(input int w, input int h);
		settle();
		cfg_write(smcs_pkg::CFG_WIDTH, w);
		cfg_write(CFG_SPARE_LO, $urandom_range(511));
		cfg_write(smcs_pkg::CFG_HEIGHT, h);
		cfg_write(CFG_SPARE_HI, $urandom_range(511));
		cfg_valid <= 1'b0;
	endtask

	task automatic test_empty_list();
		send_command(smcs_pkg::FUNC_SCORE, 0, 0, 0);
		send_command(smcs_pkg::FUNC_CLEAR, -1, -1, 255);
		score_candidate(511, -512);
	endtask

	task automatic test_grid_edges();
		send_command(smcs_pkg::FUNC_GRID_WR, 0, 0, 255);
		send_command(smcs_pkg::FUNC_GRID_WR, 255, 255, 0);
		send_command(smcs_pkg::FUNC_GRID_WR, 255, 0, 1);
		send_command(smcs_pkg::FUNC_GRID_WR, 0, 255, 128);
		// writes off the grid are dropped
		send_command(smcs_pkg::FUNC_GRID_WR, -1, 0, 170);
		send_command(smcs_pkg::FUNC_GRID_WR, 0, -512, 170);
		send_command(smcs_pkg::FUNC_GRID_WR, 256, 5, 170);
		send_command(smcs_pkg::FUNC_GRID_WR, 511, 511, 170);
		// points at the coordinate extremes
		send_command(smcs_pkg::FUNC_APPEND, 0, 0, 0);
		send_command(smcs_pkg::FUNC_APPEND, 255, 255, 0);
		send_command(smcs_pkg::FUNC_APPEND, 511, 511, 0);
		send_command(smcs_pkg::FUNC_APPEND, -512, -512, 0);
		send_command(smcs_pkg::FUNC_APPEND, -1, 0, 0);
		// one full cell out of five points floors the fraction
		score_candidate(0, 0);
		score_candidate(255, 0);
		score_candidate(-512, -512);
		score_candidate(511, 511);
		score_candidate(-255, -255);
	endtask

	task automatic test_dimension_registers();
		// zero width or height: nothing lies on the grid
		program_dims(0, 256);
		send_command(smcs_pkg::FUNC_GRID_WR, 0, 0, 7);
		score_candidate(0, 0);
		program_dims(256, 0);
		score_candidate(0, 0);
		// values above the grid side saturate
		program_dims(511, 300);
		send_command(smcs_pkg::FUNC_GRID_WR, 255, 255, 9);
		send_command(smcs_pkg::FUNC_GRID_WR, 256, 0, 9);
		score_candidate(0, 0);
		score_candidate(-255, -255);
		// single cell grid
		program_dims(1, 1);
		send_command(smcs_pkg::FUNC_GRID_WR, 0, 0, 200);
		send_command(smcs_pkg::FUNC_GRID_WR, 1, 0, 5);
		score_candidate(0, 0);
		score_candidate(1, 1);
		program_dims(257, 256);
		score_candidate(-255, -255);
		program_dims(256, 256);
	endtask

	// every point on a full cell gives a score of exactly one
	task automatic test_full_cells();
		send_command(smcs_pkg::FUNC_CLEAR, 0, 0, 0);
		for (int y = 0; y < FULL_SIDE; y++)
			for (int x = 0; x < FULL_SIDE; x++)
				send_command(smcs_pkg::FUNC_GRID_WR, x, y, 255);
		repeat (FULL_POINTS)
			send_command(smcs_pkg::FUNC_APPEND, $urandom_range(FULL_SIDE - 1),
				$urandom_range(FULL_SIDE - 1), $urandom_range(255));
		score_candidate(0, 0);
		score_candidate(1, -1);
		send_command(smcs_pkg::FUNC_CLEAR, 0, 0, 0);
		score_candidate(0, 0);
	endtask

	// hold results back so the command queue fills and the input stalls
	task automatic test_backpressure();
		in_idle_pct   = 0;
		out_stall_pct = 0;
		send_command(smcs_pkg::FUNC_CLEAR, 0, 0, 0);
		repeat (6)
			send_command(smcs_pkg::FUNC_APPEND, $urandom_range(20), $urandom_range(20), 0);
		hold_req = HOLD_CYCLES;
		repeat (12)
			score_candidate(int'($urandom_range(6)) - 3, int'($urandom_range(6)) - 3);
		settle();
	endtask

	// mostly clear / append / score sequences, the rest single random commands
	task automatic test_random_traffic(input int in_pct, input int out_pct, input int n_items,
		input int w, input int h);
		int stop_at;
		program_dims(w, h);
		in_idle_pct   = in_pct;
		out_stall_pct = out_pct;
		stop_at       = items_sent + n_items;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 80) begin
				if ($urandom_range(3) != 0)
					send_command(smcs_pkg::FUNC_CLEAR, pick_coord(), pick_coord(),
						$urandom_range(255));
				repeat ($urandom_range(1, 24))
					send_command(smcs_pkg::FUNC_APPEND, pick_point(), pick_point(),
						$urandom_range(255));
				repeat ($urandom_range(0, 3))
					send_command(smcs_pkg::FUNC_GRID_WR, pick_point(), pick_point(),
						$urandom_range(255));
				repeat ($urandom_range(1, 4))
					score_candidate(pick_shift(), pick_shift());
			end else begin
				case ($urandom_range(3))
					0: send_command(smcs_pkg::FUNC_GRID_WR, pick_coord(), pick_coord(),
						$urandom_range(255));
					1: send_command(smcs_pkg::FUNC_APPEND, pick_coord(), pick_coord(),
						$urandom_range(255));
					2: send_command(smcs_pkg::FUNC_CLEAR, pick_coord(), pick_coord(),
						$urandom_range(255));
					default: score_candidate(pick_coord(), pick_coord());
				endcase
			end
		end
	endtask

	// result side: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	// compare each result transaction with the oldest queued score
	always @(posedge clk) begin
		score_pair_t want;
		if (out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				$display("%0t: result with no score pending, expected none, actual %0d / %0d",
					$time, score_fraction, raw_sum);
				fail_count++;
			end else begin
				want = pending_scores.pop_front();
				if (score_fraction !== want.score) begin
					$display("%0t: score_fraction expected %0d actual %0d",
						$time, want.score, score_fraction);
					fail_count++;
				end
				if (raw_sum !== want.raw) begin
					$display("%0t: raw_sum expected %0d actual %0d", $time, want.raw, raw_sum);
					fail_count++;
				end
				scores_checked++;
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("scan_match_candidate_scorer regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_grid_edges();
		test_dimension_registers();
		test_full_cells();
		test_backpressure();
		test_random_traffic(0, 0, PHASE_ITEMS, 256, 256);
		test_random_traffic(78, 0, PHASE_ITEMS, $urandom_range(1, 511), $urandom_range(1, 511));
		test_random_traffic(0, 78, PHASE_ITEMS, 200, 64);
		test_random_traffic(8, 8, PHASE_ITEMS, $urandom_range(1, 511), $urandom_range(1, 511));
		settle();
		$display("covered %0d commands and %0d register writes, %0d scores checked",
			items_sent, cfg_writes, scores_checked);
		$display("point list peaked at %0d entries, grid sizes from empty to saturated",
			peak_points);
		if (fail_count == 0 && pending_scores.size() == 0)
			$display("scan_match_candidate_scorer regression: pass");
		else
			$display("scan_match_candidate_scorer regression: fail");
		$finish;
	end

endmodule
